// File: rtl/bmbe_pkg.sv
// Package for the bracket matching bytecode emitter.
// Holds the transaction payload types, opcode numbers, fault codes and command characters.
// No dependencies.
package bmbe_pkg;

    localparam int OUT_SLOT_W = 20;
    localparam int VALUE_W    = 32;

    typedef struct packed {
        logic [7:0] source_byte;
        logic       is_final;
    } in_item_t;

    typedef struct packed {
        logic [OUT_SLOT_W-1:0] write_slot;
        logic [VALUE_W-1:0]    write_value;
        logic [1:0]            fault;
        logic [OUT_SLOT_W-1:0] program_length;
        logic                  run_last;
    } out_item_t;

    localparam logic [3:0] OP_INC    = 4'd0;
    localparam logic [3:0] OP_DEC    = 4'd1;
    localparam logic [3:0] OP_LEFT   = 4'd2;
    localparam logic [3:0] OP_RIGHT  = 4'd3;
    localparam logic [3:0] OP_LOOP   = 4'd4;
    localparam logic [3:0] OP_ENDLP  = 4'd5;
    localparam logic [3:0] OP_OUTPUT = 4'd6;
    localparam logic [3:0] OP_READ   = 4'd7;
    localparam logic [3:0] OP_END    = 4'd8;
    localparam logic [3:0] OP_NONE   = 4'd0;

    localparam logic [1:0] FAULT_OK        = 2'd0;
    localparam logic [1:0] FAULT_TOO_DEEP  = 2'd1;
    localparam logic [1:0] FAULT_UNMATCHED = 2'd2;
    localparam logic [1:0] FAULT_OVERFLOW  = 2'd3;

    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_LT    = 8'h3C;
    localparam logic [7:0] CHAR_GT    = 8'h3E;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_OPEN  = 8'h5B;
    localparam logic [7:0] CHAR_CLOSE = 8'h5D;

    localparam int LOOP_SLOTS = 5;

endpackage

// File: rtl/bracket_matching_bytecode_emitter.sv
// Bracket matching bytecode emitter: turns source bytes into bytecode slot writes.
// An accepted item is held in the issue stage; its results leave through the output register.
// Throughput: one result per cycle unless result_ready stalls; an item producing n results
// (0 to 4) holds the issue stage until its last is sent, so plain commands go one per cycle.
// The open-slot stack is a synchronous one-port-read memory read once per matched close bracket.
// Reset: pointer to HEADER_SLOTS, depth zero; the stack memory is not cleared.
module bracket_matching_bytecode_emitter #(
    parameter int MAX_NESTING  = 255,
    parameter int SLOT_BITS    = 20,
    parameter int HEADER_SLOTS = 12
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  bmbe_pkg::in_item_t item,
    output logic               result_valid,
    input  logic               result_ready,
    output bmbe_pkg::out_item_t result
);
    import bmbe_pkg::*;

    localparam int DEPTH_BITS = $clog2(MAX_NESTING + 1);
    localparam int ADDR_BITS  = (MAX_NESTING > 1) ? $clog2(MAX_NESTING) : 1;
    localparam logic [SLOT_BITS:0] SLOT_LIMIT = {1'b0, {SLOT_BITS{1'b1}}};
    localparam logic [SLOT_BITS-1:0] PTR_RESET = SLOT_BITS'(HEADER_SLOTS);
    localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = DEPTH_BITS'(MAX_NESTING);

    // Architectural state.
    logic [SLOT_BITS-1:0]  slot_pointer_reg, slot_pointer_next;
    logic [DEPTH_BITS-1:0] open_depth_reg, open_depth_next;

    // Stack memory and its registered read data.
    logic [SLOT_BITS-1:0] stack_mem [MAX_NESTING];
    logic [SLOT_BITS-1:0] open_slot_reg;

    // Issue stage: the item whose results are being sent.
    logic                 b_valid_reg;
    logic [1:0]           b_idx_reg;
    logic [1:0]           b_last_reg;
    logic [SLOT_BITS-1:0] b_ptr_reg;
    logic [SLOT_BITS-1:0] b_end_ptr_reg;
    logic [3:0]           b_op_reg;
    logic [1:0]           b_fault_reg;
    logic                 b_close_reg;
    logic                 b_final_reg;

    logic      out_valid_reg;
    out_item_t out_data_reg;

    logic      accept;
    logic      emit;
    logic      b_last_fire;

    // Decode of the incoming byte.
    logic                 d_has_cmd;
    logic [3:0]           d_op;
    logic [1:0]           d_fault;
    logic                 d_push;
    logic                 d_pop;
    logic [SLOT_BITS-1:0] d_ptr_after;
    logic [DEPTH_BITS-1:0] d_depth_after;
    logic                 room1;
    logic                 room5;
    logic [1:0]           d_last;

    logic [SLOT_BITS-1:0] slot_diff;
    out_item_t            res_comb;

    assign emit        = !out_valid_reg || result_ready;
    assign b_last_fire = b_valid_reg && emit && (b_idx_reg == b_last_reg);
    assign item_ready  = !b_valid_reg || b_last_fire;
    assign accept      = item_valid && item_ready;

    assign room1 = ({1'b0, slot_pointer_reg} + (SLOT_BITS+1)'(1)) <= SLOT_LIMIT;
    assign room5 = ({1'b0, slot_pointer_reg} + (SLOT_BITS+1)'(LOOP_SLOTS)) <= SLOT_LIMIT;

    always_comb
    begin
        d_has_cmd     = 1'b1;
        d_op          = OP_NONE;
        d_fault       = FAULT_OK;
        d_push        = 1'b0;
        d_pop         = 1'b0;
        d_ptr_after   = slot_pointer_reg;
        d_depth_after = open_depth_reg;
        case (item.source_byte)
            CHAR_PLUS, CHAR_MINUS, CHAR_LT, CHAR_GT, CHAR_DOT, CHAR_COMMA:
            begin
                case (item.source_byte)
                    CHAR_PLUS:  d_op = OP_INC;
                    CHAR_MINUS: d_op = OP_DEC;
                    CHAR_LT:    d_op = OP_LEFT;
                    CHAR_GT:    d_op = OP_RIGHT;
                    CHAR_DOT:   d_op = OP_OUTPUT;
                    default:    d_op = OP_READ;
                endcase
                if (room1)
                begin
                    d_ptr_after = slot_pointer_reg + SLOT_BITS'(1);
                end
                else
                begin
                    d_op    = OP_NONE;
                    d_fault = FAULT_OVERFLOW;
                end
            end
            CHAR_OPEN:
            begin
                if (open_depth_reg >= DEPTH_MAX)
                begin
                    d_fault = FAULT_TOO_DEEP;
                end
                else if (!room5)
                begin
                    d_fault = FAULT_OVERFLOW;
                end
                else
                begin
                    d_op          = OP_LOOP;
                    d_push        = 1'b1;
                    d_depth_after = open_depth_reg + DEPTH_BITS'(1);
                    d_ptr_after   = slot_pointer_reg + SLOT_BITS'(LOOP_SLOTS);
                end
            end
            CHAR_CLOSE:
            begin
                if (open_depth_reg == '0)
                begin
                    d_fault = FAULT_UNMATCHED;
                end
                else if (!room5)
                begin
                    d_fault = FAULT_OVERFLOW;
                end
                else
                begin
                    d_op          = OP_ENDLP;
                    d_pop         = 1'b1;
                    d_depth_after = open_depth_reg - DEPTH_BITS'(1);
                    d_ptr_after   = slot_pointer_reg + SLOT_BITS'(LOOP_SLOTS);
                end
            end
            default:
            begin
                d_has_cmd = 1'b0;
            end
        endcase
    end

    // Index of the last result: command, two close writes, then end.
    always_comb
    begin
        d_last = 2'(({1'b0, d_has_cmd} + (d_pop ? 2'd2 : 2'd0) + {1'b0, item.is_final})
                    - 2'd1);
    end

    always_comb
    begin
        if (accept && item.is_final)
        begin
            slot_pointer_next = PTR_RESET;
            open_depth_next   = '0;
        end
        else if (accept)
        begin
            slot_pointer_next = d_ptr_after;
            open_depth_next   = d_depth_after;
        end
        else
        begin
            slot_pointer_next = slot_pointer_reg;
            open_depth_next   = open_depth_reg;
        end
    end

    // A push and a later pop of the same entry are always in different cycles, since one
    // item is accepted per cycle at most, so the read sees the written value without forwarding.
    always_ff @(posedge clk)
    begin
        if (accept && d_push)
        begin
            stack_mem[open_depth_reg[ADDR_BITS-1:0]] <= slot_pointer_reg;
        end
        if (accept && d_pop)
        begin
            open_slot_reg <= stack_mem[d_depth_after[ADDR_BITS-1:0]];
        end
    end

    assign slot_diff = b_ptr_reg - open_slot_reg;

    always_comb
    begin
        res_comb.fault          = FAULT_OK;
        res_comb.program_length = '0;
        res_comb.run_last       = (b_idx_reg == b_last_reg);
        if (b_final_reg && (b_idx_reg == b_last_reg))
        begin
            res_comb.write_slot     = OUT_SLOT_W'(b_end_ptr_reg);
            res_comb.write_value    = VALUE_W'(OP_END);
            res_comb.program_length = OUT_SLOT_W'(b_end_ptr_reg);
        end
        else
        begin
            case (b_idx_reg)
                2'd1:
                begin
                    res_comb.write_slot  = OUT_SLOT_W'(b_ptr_reg + SLOT_BITS'(1));
                    res_comb.write_value = VALUE_W'(slot_diff);
                end
                2'd2:
                begin
                    res_comb.write_slot  = OUT_SLOT_W'(open_slot_reg + SLOT_BITS'(1));
                    res_comb.write_value = VALUE_W'(slot_diff);
                end
                default:
                begin
                    res_comb.write_slot  = OUT_SLOT_W'(b_ptr_reg);
                    res_comb.write_value = VALUE_W'(b_op_reg);
                    res_comb.fault       = b_fault_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_pointer_reg <= PTR_RESET;
            open_depth_reg   <= '0;
            b_valid_reg      <= 1'b0;
            b_idx_reg        <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            slot_pointer_reg <= slot_pointer_next;
            open_depth_reg   <= open_depth_next;
            if (b_valid_reg && emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (accept)
            begin
                b_valid_reg <= d_has_cmd || item.is_final;
                b_idx_reg   <= '0;
            end
            else if (b_last_fire)
            begin
                b_valid_reg <= 1'b0;
            end
            else if (b_valid_reg && emit)
            begin
                b_idx_reg <= b_idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_valid_reg && emit)
        begin
            out_data_reg <= res_comb;
        end
        if (accept)
        begin
            b_last_reg    <= d_last;
            b_ptr_reg     <= slot_pointer_reg;
            b_end_ptr_reg <= d_ptr_after;
            b_op_reg      <= d_op;
            b_fault_reg   <= d_fault;
            b_close_reg   <= d_pop;
            b_final_reg   <= item.is_final;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

    // The nesting count never passes the stack depth.
    assert property (@(posedge clk) disable iff (!rst_n) open_depth_reg <= DEPTH_MAX)
        else $error("open depth beyond stack depth");

    // A matched close always lies after its open bracket.
    assert property (@(posedge clk) disable iff (!rst_n)
        (b_valid_reg && b_close_reg) |-> (b_ptr_reg > open_slot_reg))
        else $error("close slot not after its open slot");

    // The two offset writes of a close carry the same distance.
    assert property (@(posedge clk) disable iff (!rst_n)
        (b_valid_reg && b_close_reg && emit && (b_idx_reg == 2'd1) && !b_last_fire)
        |=> (out_data_reg.write_value == res_comb.write_value))
        else $error("backpatch distance differs from loop end distance");

endmodule
